// ===== design/sfla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

    // Heap geometry
    localparam int BLOCK_BYTES = 65536;
    localparam int BLOCKS      = 4;
    localparam int BIN_COUNT   = 6;
    localparam int MIN_CHUNK   = 24;
    localparam int HDR_BYTES   = 8;
    localparam int SPLIT_MIN   = 32;
    localparam int FLOOR_CHUNK = (MIN_CHUNK + 7) / 8 * 8;
    localparam int GRANS       = BLOCK_BYTES / 8;
    localparam int TOP_BIN     = BIN_COUNT - 1;

    // Widths
    localparam int GRAN_W   = $clog2(GRANS);
    localparam int BLK_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int ADDR_W   = BLK_W + GRAN_W;
    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int SIZE_W   = OFF_W + 1;
    localparam int ACT_W    = $clog2(BLOCKS + 1);
    localparam int BIN_W    = $clog2(BIN_COUNT + 1);
    localparam int LIVE_W   = 14;
    localparam int REQ_W    = 24;
    localparam int HANDLE_W = 18;
    localparam int MAXB_W   = 3;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FAIL    = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    // One header per 8-byte granule
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [GRAN_W-1:0] next;
        logic [GRAN_W-1:0] prev;
        logic              free;
        logic              start;
        logic              next_ok;
        logic              prev_ok;
    } hdr_t;

    typedef struct packed {
        logic [GRAN_W-1:0] at;
        logic              ok;
    } head_t;

    typedef struct packed {
        op_t                 op;
        logic [REQ_W-1:0]    request_size;
        logic [HANDLE_W-1:0] handle;
        logic                handle_valid;
    } req_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] result_handle;
        status_t             status;
        logic                copy_needed;
        logic [REQ_W-1:0]    copy_bytes;
        logic [HANDLE_W-1:0] copy_from;
    } res_item_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        hdr_t              wdata;
    } mem_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOC,
        S_LOC_WAIT,
        S_RE_CHK,
        S_REL,
        S_FOL_WAIT,
        S_REL_MERGE,
        S_REL_PUSH,
        S_GROW_A,
        S_GROW_W,
        S_RE_MOVE,
        S_REL_READ,
        S_REL_RWAIT,
        S_AL_START,
        S_AS_BLK,
        S_AS_BIN,
        S_AS_WAIT,
        S_AL_SPLIT,
        S_AL_WR,
        S_AS_END,
        S_SWEEP,
        S_D0,
        S_D1,
        S_D3,
        S_D4,
        S_P0,
        S_P1,
        S_P2,
        S_FINISH
    } state_t;

    // Size class of a chunk
    function automatic logic [BIN_W-1:0] size_class(input logic [SIZE_W-1:0] s);
        logic [BIN_W-1:0] c;
        if (s <= SIZE_W'(32))       c = BIN_W'(0);
        else if (s <= SIZE_W'(64))  c = BIN_W'(1);
        else if (s <= SIZE_W'(128)) c = BIN_W'(2);
        else if (s <= SIZE_W'(256)) c = BIN_W'(3);
        else if (s <= SIZE_W'(512)) c = BIN_W'(4);
        else                        c = BIN_W'(5);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/sfla_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      en,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem_array[addr] <= wdata;
            end else begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/sfla_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfla_ctrl (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  sfla_pkg::req_item_t        in_item,
    input  wire  [sfla_pkg::MAXB_W-1:0] max_blocks,
    output logic                       out_valid,
    input  wire                        out_ready,
    output sfla_pkg::res_item_t        out_item,
    output sfla_pkg::mem_req_t         mem,
    input  sfla_pkg::hdr_t             mem_rdata
);
    import sfla_pkg::*;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    op_t                 op_reg, op_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic                hv_reg, hv_next;
    logic [SIZE_W-1:0]   t_reg, t_next;
    logic                tbig_reg, tbig_next;
    logic [BLK_W-1:0]    b_reg, b_next;
    logic [GRAN_W-1:0]   g_reg, g_next;
    hdr_t                h_reg, h_next;
    hdr_t                n_reg, n_next;
    logic [GRAN_W-1:0]   ng_reg, ng_next;
    hdr_t                x_reg, x_next;
    logic [GRAN_W-1:0]   xg_reg, xg_next;
    logic [BLK_W-1:0]    xb_reg, xb_next;
    logic [ACT_W-1:0]    sb_reg, sb_next;
    logic [GRAN_W-1:0]   sg_reg, sg_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic                pass_reg, pass_next;
    logic                move_reg, move_next;
    logic                rel_reg, rel_next;
    logic [GRAN_W-1:0]   k_reg, k_next;
    logic [BLK_W-1:0]    swb_reg, swb_next;
    logic                swadd_reg, swadd_next;
    logic [ACT_W-1:0]    active_reg, active_next;
    head_t               heads_reg [BLOCKS][BIN_COUNT];
    head_t               heads_next [BLOCKS][BIN_COUNT];
    logic [SIZE_W-1:0]   bfb_reg [BLOCKS];
    logic [SIZE_W-1:0]   bfb_next [BLOCKS];
    logic [LIVE_W-1:0]   live_reg [BLOCKS];
    logic [LIVE_W-1:0]   live_next [BLOCKS];
    res_item_t           res_reg, res_next;

    // Shared read ports of the small tables
    logic [BLK_W-1:0]  hidx_b;
    logic [BIN_W-1:0]  hidx_bin;
    head_t             hd_rd;
    logic [BLK_W-1:0]  fidx;
    logic [SIZE_W-1:0] bfb_rd;
    logic [LIVE_W-1:0] live_rd;

    always_comb begin
        if (state_reg == S_AS_BIN) begin
            hidx_b   = sb_reg[BLK_W-1:0];
            hidx_bin = bin_reg;
        end else begin
            hidx_b   = xb_reg;
            hidx_bin = size_class(x_reg.size);
        end
        hd_rd = heads_reg[hidx_b][hidx_bin];
        if (state_reg == S_AS_BLK || state_reg == S_AL_WR) begin
            fidx = sb_reg[BLK_W-1:0];
        end else begin
            fidx = b_reg;
        end
        bfb_rd  = bfb_reg[fidx];
        live_rd = live_reg[fidx];
    end

    // Request decode helpers
    logic [REQ_W:0]      tsum;
    logic [REQ_W:0]      tfull;
    logic [HANDLE_W-1:0] off;
    logic [HANDLE_W-1:0] loc_b_full;
    logic [HANDLE_W-1:0] nxt;
    logic [SIZE_W:0]     comb_sz;
    logic [SIZE_W:0]     rem_grow;
    logic [SIZE_W-1:0]   rem_al;
    logic [SIZE_W-1:0]   old_data;
    hdr_t                wtmp;
    hdr_t                init_hdr;

    always_comb begin
        tsum = {1'b0, in_item.request_size} + (REQ_W + 1)'(15);
        tfull = tsum & ~((REQ_W + 1)'(7));
        if (tfull < (REQ_W + 1)'(FLOOR_CHUNK)) begin
            tfull = (REQ_W + 1)'(FLOOR_CHUNK);
        end
        off        = handle_reg - HANDLE_W'(HDR_BYTES);
        loc_b_full = off >> OFF_W;
        nxt        = HANDLE_W'({g_reg, 3'b000}) + HANDLE_W'(h_reg.size);
        comb_sz    = {1'b0, h_reg.size} + {1'b0, mem_rdata.size};
        rem_grow   = {1'b0, h_reg.size} + {1'b0, n_reg.size} - {1'b0, t_reg};
        rem_al     = h_reg.size - t_reg;
        old_data   = h_reg.size - SIZE_W'(HDR_BYTES);
        init_hdr       = '0;
        init_hdr.size  = SIZE_W'(BLOCK_BYTES);
        init_hdr.free  = 1'b1;
        init_hdr.start = 1'b1;
    end

    // Next state and datapath
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        op_next     = op_reg;
        req_next    = req_reg;
        handle_next = handle_reg;
        hv_next     = hv_reg;
        t_next      = t_reg;
        tbig_next   = tbig_reg;
        b_next      = b_reg;
        g_next      = g_reg;
        h_next      = h_reg;
        n_next      = n_reg;
        ng_next     = ng_reg;
        x_next      = x_reg;
        xg_next     = xg_reg;
        xb_next     = xb_reg;
        sb_next     = sb_reg;
        sg_next     = sg_reg;
        bin_next    = bin_reg;
        pass_next   = pass_reg;
        move_next   = move_reg;
        rel_next    = rel_reg;
        k_next      = k_reg;
        swb_next    = swb_reg;
        swadd_next  = swadd_reg;
        active_next = active_reg;
        heads_next  = heads_reg;
        bfb_next    = bfb_reg;
        live_next   = live_reg;
        res_next    = res_reg;
        wtmp        = mem_rdata;
        mem         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_item.op;
                    req_next    = in_item.request_size;
                    handle_next = in_item.handle;
                    hv_next     = in_item.handle_valid;
                    t_next      = tfull[SIZE_W-1:0];
                    tbig_next   = tfull > (REQ_W + 1)'(BLOCK_BYTES);
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                res_next  = '0;
                move_next = 1'b0;
                rel_next  = 1'b0;
                case (op_reg)
                    OP_ALLOC: state_next = S_AL_START;
                    OP_FREE: state_next = hv_reg ? S_LOC : S_FINISH;
                    OP_REALLOC: state_next = hv_reg ? S_LOC : S_AL_START;
                    default: begin
                        active_next = ACT_W'(1);
                        swb_next    = '0;
                        swadd_next  = 1'b0;
                        k_next      = '0;
                        ret_next    = S_FINISH;
                        state_next  = S_SWEEP;
                    end
                endcase
            end

            // Check the handle, then read its header
            S_LOC: begin
                b_next = loc_b_full[BLK_W-1:0];
                g_next = off[OFF_W-1:3];
                if (handle_reg < HANDLE_W'(HDR_BYTES) || off[2:0] != 3'b000
                        || loc_b_full >= HANDLE_W'(active_reg)) begin
                    res_next.status = STAT_IGNORED;
                    state_next      = S_FINISH;
                end else begin
                    mem.en     = 1'b1;
                    mem.addr   = {loc_b_full[BLK_W-1:0], off[OFF_W-1:3]};
                    state_next = S_LOC_WAIT;
                end
            end

            S_LOC_WAIT: begin
                h_next = mem_rdata;
                if (!(mem_rdata.start && !mem_rdata.free)) begin
                    res_next.status = STAT_IGNORED;
                    state_next      = S_FINISH;
                end else if (op_reg == OP_FREE) begin
                    rel_next   = 1'b1;
                    state_next = S_REL;
                end else begin
                    state_next = S_RE_CHK;
                end
            end

            S_RE_CHK: begin
                if (!tbig_reg && h_reg.size >= t_reg) begin
                    res_next.result_handle = handle_reg;
                    state_next             = S_FINISH;
                end else if (nxt >= HANDLE_W'(BLOCK_BYTES)) begin
                    state_next = S_RE_MOVE;
                end else begin
                    ng_next    = nxt[OFF_W-1:3];
                    mem.en     = 1'b1;
                    mem.addr   = {b_reg, nxt[OFF_W-1:3]};
                    state_next = S_FOL_WAIT;
                end
            end

            // Release: account, then look at the follower
            S_REL: begin
                bfb_next[b_reg] = bfb_rd + h_reg.size;
                if (live_rd != '0) begin
                    live_next[b_reg] = live_rd - LIVE_W'(1);
                end
                if (nxt >= HANDLE_W'(BLOCK_BYTES)) begin
                    state_next = S_REL_PUSH;
                end else begin
                    ng_next    = nxt[OFF_W-1:3];
                    mem.en     = 1'b1;
                    mem.addr   = {b_reg, nxt[OFF_W-1:3]};
                    state_next = S_FOL_WAIT;
                end
            end

            S_FOL_WAIT: begin
                n_next = mem_rdata;
                if (rel_reg) begin
                    if (mem_rdata.start && mem_rdata.free) begin
                        x_next     = mem_rdata;
                        xg_next    = ng_reg;
                        xb_next    = b_reg;
                        ret_next   = S_REL_MERGE;
                        state_next = S_D0;
                    end else begin
                        state_next = S_REL_PUSH;
                    end
                end else if (mem_rdata.start && mem_rdata.free && !tbig_reg
                        && comb_sz >= {1'b0, t_reg}) begin
                    x_next     = mem_rdata;
                    xg_next    = ng_reg;
                    xb_next    = b_reg;
                    ret_next   = S_GROW_A;
                    state_next = S_D0;
                end else begin
                    state_next = S_RE_MOVE;
                end
            end

            S_REL_MERGE: begin
                wtmp       = '0;
                wtmp.size  = n_reg.size;
                mem.en     = 1'b1;
                mem.we     = 1'b1;
                mem.addr   = {b_reg, ng_reg};
                mem.wdata  = wtmp;
                h_next.size = h_reg.size + n_reg.size;
                state_next = S_REL_PUSH;
            end

            S_REL_PUSH: begin
                x_next       = h_reg;
                x_next.free  = 1'b1;
                x_next.start = 1'b1;
                xg_next      = g_reg;
                xb_next      = b_reg;
                ret_next     = S_FINISH;
                state_next   = S_P0;
            end

            // Grow in place into the free follower
            S_GROW_A: begin
                wtmp      = '0;
                wtmp.size = n_reg.size;
                mem.en    = 1'b1;
                mem.we    = 1'b1;
                mem.addr  = {b_reg, ng_reg};
                mem.wdata = wtmp;
                if (rem_grow >= (SIZE_W + 1)'(SPLIT_MIN)) begin
                    x_next       = '0;
                    x_next.size  = rem_grow[SIZE_W-1:0];
                    x_next.free  = 1'b1;
                    x_next.start = 1'b1;
                    xg_next      = g_reg + t_reg[GRAN_W+2:3];
                    xb_next      = b_reg;
                    bfb_next[b_reg] = bfb_rd - (t_reg - h_reg.size);
                    h_next.size  = t_reg;
                    ret_next     = S_GROW_W;
                    state_next   = S_P0;
                end else begin
                    h_next.size     = h_reg.size + n_reg.size;
                    bfb_next[b_reg] = bfb_rd - n_reg.size;
                    state_next      = S_GROW_W;
                end
            end

            S_GROW_W: begin
                mem.en    = 1'b1;
                mem.we    = 1'b1;
                mem.addr  = {b_reg, g_reg};
                mem.wdata = h_reg;
                res_next.result_handle = handle_reg;
                state_next = S_FINISH;
            end

            S_RE_MOVE: begin
                res_next.copy_bytes = ({7'b0, old_data} < req_reg) ?
                                      {7'b0, old_data} : req_reg;
                res_next.copy_from  = handle_reg;
                move_next           = 1'b1;
                state_next          = S_AL_START;
            end

            S_REL_READ: begin
                mem.en     = 1'b1;
                mem.addr   = {b_reg, g_reg};
                state_next = S_REL_RWAIT;
            end

            S_REL_RWAIT: begin
                h_next     = mem_rdata;
                rel_next   = 1'b1;
                state_next = S_REL;
            end

            // First-fit search
            S_AL_START: begin
                if (req_reg == '0 || tbig_reg) begin
                    res_next        = '0;
                    res_next.status = STAT_FAIL;
                    state_next      = S_FINISH;
                end else begin
                    pass_next  = 1'b0;
                    sb_next    = '0;
                    state_next = S_AS_BLK;
                end
            end

            S_AS_BLK: begin
                if (sb_reg >= active_reg) begin
                    state_next = S_AS_END;
                end else if (bfb_rd < t_reg) begin
                    sb_next = sb_reg + ACT_W'(1);
                end else begin
                    bin_next   = size_class(t_reg);
                    state_next = S_AS_BIN;
                end
            end

            S_AS_BIN: begin
                if (bin_reg >= BIN_W'(BIN_COUNT)) begin
                    sb_next    = sb_reg + ACT_W'(1);
                    state_next = S_AS_BLK;
                end else if (hd_rd.ok) begin
                    sg_next    = hd_rd.at;
                    mem.en     = 1'b1;
                    mem.addr   = {sb_reg[BLK_W-1:0], hd_rd.at};
                    state_next = S_AS_WAIT;
                end else begin
                    bin_next = bin_reg + BIN_W'(1);
                end
            end

            S_AS_WAIT: begin
                if (mem_rdata.size >= t_reg) begin
                    h_next     = mem_rdata;
                    x_next     = mem_rdata;
                    xg_next    = sg_reg;
                    xb_next    = sb_reg[BLK_W-1:0];
                    ret_next   = S_AL_SPLIT;
                    state_next = S_D0;
                end else if (mem_rdata.next_ok) begin
                    sg_next  = mem_rdata.next;
                    mem.en   = 1'b1;
                    mem.addr = {sb_reg[BLK_W-1:0], mem_rdata.next};
                end else begin
                    bin_next   = bin_reg + BIN_W'(1);
                    state_next = S_AS_BIN;
                end
            end

            S_AL_SPLIT: begin
                if (rem_al >= SIZE_W'(SPLIT_MIN)) begin
                    x_next       = '0;
                    x_next.size  = rem_al;
                    x_next.free  = 1'b1;
                    x_next.start = 1'b1;
                    xg_next      = sg_reg + t_reg[GRAN_W+2:3];
                    xb_next      = sb_reg[BLK_W-1:0];
                    h_next.size  = t_reg;
                    ret_next     = S_AL_WR;
                    state_next   = S_P0;
                end else begin
                    state_next = S_AL_WR;
                end
            end

            S_AL_WR: begin
                wtmp       = '0;
                wtmp.size  = h_reg.size;
                wtmp.start = 1'b1;
                mem.en     = 1'b1;
                mem.we     = 1'b1;
                mem.addr   = {sb_reg[BLK_W-1:0], sg_reg};
                mem.wdata  = wtmp;
                bfb_next[sb_reg[BLK_W-1:0]]  = bfb_rd - h_reg.size;
                live_next[sb_reg[BLK_W-1:0]] = live_rd + LIVE_W'(1);
                res_next.result_handle = HANDLE_W'({sb_reg[BLK_W-1:0], sg_reg, 3'b000})
                                         + HANDLE_W'(HDR_BYTES);
                res_next.status = STAT_OK;
                if (move_reg) begin
                    res_next.copy_needed = 1'b1;
                    state_next           = S_REL_READ;
                end else begin
                    state_next = S_FINISH;
                end
            end

            // Nothing fit: add a block once, or give up
            S_AS_END: begin
                if (pass_reg || active_reg >= ACT_W'(BLOCKS)
                        || (max_blocks != '0 && 32'(active_reg) >= 32'(max_blocks))) begin
                    res_next        = '0;
                    res_next.status = STAT_FAIL;
                    state_next      = S_FINISH;
                end else begin
                    swb_next   = active_reg[BLK_W-1:0];
                    swadd_next = 1'b1;
                    k_next     = '0;
                    pass_next  = 1'b1;
                    sb_next    = '0;
                    ret_next   = S_AS_BLK;
                    state_next = S_SWEEP;
                end
            end

            // Block init: clear every header, entry 0 is the whole block
            S_SWEEP: begin
                mem.en    = 1'b1;
                mem.we    = 1'b1;
                mem.addr  = {swb_reg, k_reg};
                mem.wdata = (k_reg == '0) ? init_hdr : '0;
                if (k_reg == GRAN_W'(GRANS - 1)) begin
                    for (int i = 0; i < BIN_COUNT; i++) begin
                        heads_next[swb_reg][i] = '0;
                    end
                    heads_next[swb_reg][TOP_BIN].ok = 1'b1;
                    bfb_next[swb_reg]  = SIZE_W'(BLOCK_BYTES);
                    live_next[swb_reg] = '0;
                    if (swadd_reg) begin
                        active_next = active_reg + ACT_W'(1);
                    end
                    state_next = ret_reg;
                end else begin
                    k_next = k_reg + GRAN_W'(1);
                end
            end

            // Unlink x from its bin
            S_D0: begin
                if (x_reg.prev_ok) begin
                    mem.en     = 1'b1;
                    mem.addr   = {xb_reg, x_reg.prev};
                    state_next = S_D1;
                end else begin
                    heads_next[hidx_b][hidx_bin].at = x_reg.next;
                    heads_next[hidx_b][hidx_bin].ok = x_reg.next_ok;
                    state_next = S_D3;
                end
            end

            S_D1: begin
                wtmp.next    = x_reg.next;
                wtmp.next_ok = x_reg.next_ok;
                mem.en       = 1'b1;
                mem.we       = 1'b1;
                mem.addr     = {xb_reg, x_reg.prev};
                mem.wdata    = wtmp;
                state_next   = S_D3;
            end

            S_D3: begin
                if (x_reg.next_ok) begin
                    mem.en     = 1'b1;
                    mem.addr   = {xb_reg, x_reg.next};
                    state_next = S_D4;
                end else begin
                    state_next = ret_reg;
                end
            end

            S_D4: begin
                wtmp.prev    = x_reg.prev;
                wtmp.prev_ok = x_reg.prev_ok;
                mem.en       = 1'b1;
                mem.we       = 1'b1;
                mem.addr     = {xb_reg, x_reg.next};
                mem.wdata    = wtmp;
                state_next   = ret_reg;
            end

            // Push x at the head of its bin
            S_P0: begin
                wtmp         = x_reg;
                wtmp.prev    = '0;
                wtmp.prev_ok = 1'b0;
                wtmp.next    = hd_rd.at;
                wtmp.next_ok = hd_rd.ok;
                x_next       = wtmp;
                mem.en       = 1'b1;
                mem.we       = 1'b1;
                mem.addr     = {xb_reg, xg_reg};
                mem.wdata    = wtmp;
                heads_next[hidx_b][hidx_bin].at = xg_reg;
                heads_next[hidx_b][hidx_bin].ok = 1'b1;
                state_next = hd_rd.ok ? S_P1 : ret_reg;
            end

            S_P1: begin
                mem.en     = 1'b1;
                mem.addr   = {xb_reg, x_reg.next};
                state_next = S_P2;
            end

            S_P2: begin
                wtmp.prev    = xg_reg;
                wtmp.prev_ok = 1'b1;
                mem.en       = 1'b1;
                mem.we       = 1'b1;
                mem.addr     = {xb_reg, x_reg.next};
                mem.wdata    = wtmp;
                state_next   = ret_reg;
            end

            S_FINISH: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_item = res_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_SWEEP;
            ret_reg    <= S_IDLE;
            k_reg      <= '0;
            swb_reg    <= '0;
            swadd_reg  <= 1'b0;
            active_reg <= ACT_W'(1);
            pass_reg   <= 1'b0;
            move_reg   <= 1'b0;
            rel_reg    <= 1'b0;
            for (int i = 0; i < BLOCKS; i++) begin
                for (int j = 0; j < BIN_COUNT; j++) begin
                    heads_reg[i][j] <= '0;
                end
                bfb_reg[i]  <= '0;
                live_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            k_reg      <= k_next;
            swb_reg    <= swb_next;
            swadd_reg  <= swadd_next;
            active_reg <= active_next;
            pass_reg   <= pass_next;
            move_reg   <= move_next;
            rel_reg    <= rel_next;
            heads_reg  <= heads_next;
            bfb_reg    <= bfb_next;
            live_reg   <= live_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        req_reg    <= req_next;
        handle_reg <= handle_next;
        hv_reg     <= hv_next;
        t_reg      <= t_next;
        tbig_reg   <= tbig_next;
        b_reg      <= b_next;
        g_reg      <= g_next;
        h_reg      <= h_next;
        n_reg      <= n_next;
        ng_reg     <= ng_next;
        x_reg      <= x_next;
        xg_reg     <= xg_next;
        xb_reg     <= xb_next;
        sb_reg     <= sb_next;
        sg_reg     <= sg_next;
        bin_reg    <= bin_next;
        res_reg    <= res_next;
    end

    // Checks
    a_active_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg != '0 && active_reg <= ACT_W'(BLOCKS))
        else $error("active block count out of range");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == S_DISPATCH)
        else $error("accepted item not dispatched");

    a_write_active: assert property (@(posedge aclk) disable iff (!aresetn)
        mem.en && mem.we && state_reg != S_SWEEP
        |-> 32'(mem.addr[ADDR_W-1 -: BLK_W]) < 32'(active_reg))
        else $error("header write into inactive block");

    a_copy_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_item.copy_needed |-> out_item.status == STAT_OK)
        else $error("copy reported on failed item");

endmodule

`default_nettype wire

// ===== design/segregated_free_list_allocator.sv =====
// Segregated-fit heap allocator over four 64 KiB blocks. Each item (alloc, free, realloc,
// clear) gives exactly one result item. Chunk headers live in a single-port header RAM
// with registered reads; every list step is a read then a write, so an item takes longer
// for every chunk walked on a free list. Adding a block or a clear initializes the headers
// of that block (for a clear, block 0) at one entry per cycle, all 8192 entries. After
// reset, block 0 is initialized the same way: s_tready stays low until that is done.
// Configuration writes on cfg_* are taken at any time and only while the allocator is idle
// are they meant to change max_blocks. A finished result waits in an output register
// while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module segregated_free_list_allocator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // request_size[23:0], handle[41:24], zero pad
    input  wire  [2:0]  s_tuser,   // op[1:0], handle_valid[2]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // result_handle[17:0], copy_bytes[41:18], copy_from[59:42]
    output logic [2:0]  m_tuser,   // status[1:0], copy_needed[2]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_data   // max_blocks
);
    import sfla_pkg::*;

    logic [MAXB_W-1:0] max_blocks_reg;
    req_item_t         in_item;
    res_item_t         core_item;
    logic              core_valid;
    logic              core_ready;
    res_item_t         out_item_reg;
    logic              out_valid_reg;
    mem_req_t          mem;
    logic [$bits(hdr_t)-1:0] mem_rdata;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_blocks_reg <= '0;
        end else if (cfg_valid) begin
            max_blocks_reg <= cfg_data;
        end
    end

    // Input unpack
    always_comb begin
        in_item.op           = op_t'(s_tuser[1:0]);
        in_item.handle_valid = s_tuser[2];
        in_item.request_size = s_tdata[23:0];
        in_item.handle       = s_tdata[41:24];
    end

    sfla_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .max_blocks (max_blocks_reg),
        .out_valid  (core_valid),
        .out_ready  (core_ready),
        .out_item   (core_item),
        .mem        (mem),
        .mem_rdata  (mem_rdata)
    );

    sfla_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (BLOCKS * GRANS)
    ) u_hdr_ram (
        .clk   (aclk),
        .en    (mem.en),
        .we    (mem.we),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (mem_rdata)
    );

    // Output register
    assign core_ready = !out_valid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_ready) begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_ready && core_valid) begin
            out_item_reg <= core_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_item_reg.copy_from, out_item_reg.copy_bytes,
                       out_item_reg.result_handle};
    assign m_tuser  = {out_item_reg.copy_needed, out_item_reg.status};

endmodule

`default_nettype wire

// ===== tb/sv/tb_segregated_free_list_allocator.sv =====
`timescale 1ns / 1ps

module tb_segregated_free_list_allocator;
    import sfla_pkg::*;

    localparam int SLOT_COUNT = BLOCKS * GRANS;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata = '0;   // request_size[23:0], handle[41:24], zero pad
    logic [2:0]  s_tuser = '0;   // op[1:0], handle_valid[2]
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [63:0] m_tdata;        // result_handle[17:0], copy_bytes[41:18], copy_from[59:42]
    wire  [2:0]  m_tuser;        // status[1:0], copy_needed[2]
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_data = '0;

    segregated_free_list_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Heap shadow: chunk headers, bin heads, per-block counters
    int unsigned hp_size [SLOT_COUNT];
    int unsigned hp_next [SLOT_COUNT];
    int unsigned hp_prev [SLOT_COUNT];
    bit          hp_free [SLOT_COUNT];
    bit          hp_start[SLOT_COUNT];
    bit          hp_nok  [SLOT_COUNT];
    bit          hp_pok  [SLOT_COUNT];
    int unsigned bin_at  [BLOCKS*BIN_COUNT];
    bit          bin_ok  [BLOCKS*BIN_COUNT];
    int unsigned blk_free[BLOCKS];
    int unsigned blk_live[BLOCKS];
    int unsigned active_cnt;
    int unsigned block_limit;

    res_item_t   pending_results[$];
    int unsigned live_handles[$];
    int unsigned dead_handles[$];
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          errors = 0;

    function automatic int unsigned slot(int unsigned b, int unsigned g);
        return (b % BLOCKS) * GRANS + (g % GRANS);
    endfunction

    function automatic int unsigned bin_index(int unsigned b, int unsigned sz);
        int unsigned c;
        if (sz <= 32) c = 0;
        else if (sz <= 64) c = 1;
        else if (sz <= 128) c = 2;
        else if (sz <= 256) c = 3;
        else if (sz <= 512) c = 4;
        else c = 5;
        return (b % BLOCKS) * BIN_COUNT + c;
    endfunction

    function automatic void bin_push(int unsigned b, int unsigned g);
        int unsigned s, h;
        s = slot(b, g);
        h = bin_index(b, hp_size[s]);
        hp_pok[s] = 0;
        hp_prev[s] = 0;
        hp_nok[s] = bin_ok[h];
        hp_next[s] = bin_at[h];
        if (bin_ok[h]) begin
            hp_prev[slot(b, bin_at[h])] = g;
            hp_pok[slot(b, bin_at[h])] = 1;
        end
        bin_at[h] = g;
        bin_ok[h] = 1;
    endfunction

    function automatic void bin_unlink(int unsigned b, int unsigned g);
        int unsigned s, h;
        s = slot(b, g);
        h = bin_index(b, hp_size[s]);
        if (hp_pok[s]) begin
            hp_next[slot(b, hp_prev[s])] = hp_next[s];
            hp_nok[slot(b, hp_prev[s])] = hp_nok[s];
        end else begin
            bin_at[h] = hp_next[s];
            bin_ok[h] = hp_nok[s];
        end
        if (hp_nok[s]) begin
            hp_prev[slot(b, hp_next[s])] = hp_prev[s];
            hp_pok[slot(b, hp_next[s])] = hp_pok[s];
        end
        hp_next[s] = 0; hp_prev[s] = 0; hp_nok[s] = 0; hp_pok[s] = 0;
    endfunction

    function automatic void make_free_chunk(int unsigned b, int unsigned g, int unsigned sz);
        hp_size[slot(b, g)] = sz;
        hp_free[slot(b, g)] = 1;
        hp_start[slot(b, g)] = 1;
        bin_push(b, g);
    endfunction

    function automatic void wipe_block(int unsigned b);
        for (int g = 0; g < GRANS; g++) begin
            hp_size[slot(b, g)] = 0; hp_next[slot(b, g)] = 0; hp_prev[slot(b, g)] = 0;
            hp_free[slot(b, g)] = 0; hp_start[slot(b, g)] = 0;
            hp_nok[slot(b, g)] = 0; hp_pok[slot(b, g)] = 0;
        end
        for (int k = 0; k < BIN_COUNT; k++) begin
            bin_at[b*BIN_COUNT+k] = 0;
            bin_ok[b*BIN_COUNT+k] = 0;
        end
        blk_free[b] = BLOCK_BYTES;
        blk_live[b] = 0;
        make_free_chunk(b, 0, BLOCK_BYTES);
    endfunction

    function automatic void heap_reset();
        for (int b = 1; b < BLOCKS; b++) begin
            wipe_block(b);
            blk_free[b] = 0;
            bin_ok[b*BIN_COUNT+TOP_BIN] = 0;
            hp_start[slot(b, 0)] = 0;
            hp_free[slot(b, 0)] = 0;
            hp_size[slot(b, 0)] = 0;
        end
        block_limit = 0;
        active_cnt = 1;
        wipe_block(0);
    endfunction

    function automatic int unsigned chunk_need(int unsigned req);
        int unsigned t;
        t = (req + HDR_BYTES + 7) & ~32'd7;
        return (t < FLOOR_CHUNK) ? FLOOR_CHUNK : t;
    endfunction

    // First fit over active blocks, one extra block on a miss
    function automatic bit heap_alloc(int unsigned req, output int unsigned hnd);
        int unsigned t, g, s, cls;
        bit ok;
        hnd = 0;
        if (req == 0) return 0;
        t = chunk_need(req);
        if (t > BLOCK_BYTES) return 0;
        cls = bin_index(0, t);
        for (int pass = 0; pass < 2; pass++) begin
            for (int unsigned b = 0; b < active_cnt && b < BLOCKS; b++) begin
                if (blk_free[b] < t) continue;
                for (int unsigned bn = cls; bn < BIN_COUNT; bn++) begin
                    ok = bin_ok[b*BIN_COUNT+bn];
                    g = bin_at[b*BIN_COUNT+bn];
                    while (ok) begin
                        s = slot(b, g);
                        if (hp_size[s] >= t) begin
                            bin_unlink(b, g);
                            if (hp_size[s] - t >= SPLIT_MIN) begin
                                make_free_chunk(b, g + t/8, hp_size[s] - t);
                                hp_size[s] = t;
                            end
                            hp_free[s] = 0;
                            blk_free[b] -= hp_size[s];
                            blk_live[b]++;
                            hnd = b * BLOCK_BYTES + g * 8 + HDR_BYTES;
                            return 1;
                        end
                        ok = hp_nok[s];
                        g = hp_next[s];
                    end
                end
            end
            if (pass == 0) begin
                if (block_limit > 0 && active_cnt >= block_limit) return 0;
                if (active_cnt >= BLOCKS) return 0;
                wipe_block(active_cnt);
                active_cnt++;
            end
        end
        return 0;
    endfunction

    function automatic bit find_live(int unsigned hnd, output int unsigned b,
                                     output int unsigned g);
        int unsigned off;
        b = 0; g = 0;
        if (hnd < HDR_BYTES) return 0;
        off = hnd - HDR_BYTES;
        b = off / BLOCK_BYTES;
        if (b >= active_cnt || b >= BLOCKS || (off % 8) != 0) return 0;
        g = (off % BLOCK_BYTES) / 8;
        return hp_start[slot(b, g)] && !hp_free[slot(b, g)];
    endfunction

    function automatic bit next_is_free(int unsigned b, int unsigned g, output int unsigned ng);
        int unsigned nxt;
        nxt = g * 8 + hp_size[slot(b, g)];
        ng = nxt / 8;
        if (nxt >= BLOCK_BYTES) return 0;
        return hp_start[slot(b, ng)] && hp_free[slot(b, ng)];
    endfunction

    function automatic void give_back(int unsigned b, int unsigned g);
        int unsigned s, freed, ng;
        s = slot(b, g);
        freed = hp_size[s];
        if (next_is_free(b, g, ng)) begin
            bin_unlink(b, ng);
            hp_size[s] += hp_size[slot(b, ng)];
            hp_start[slot(b, ng)] = 0;
            hp_free[slot(b, ng)] = 0;
        end
        hp_free[s] = 1;
        blk_free[b] += freed;
        if (blk_live[b] > 0) blk_live[b]--;
        bin_push(b, g);
    endfunction

    // Expected result of one request; also keeps the handle pools current
    function automatic res_item_t heap_step(op_t op, int unsigned req, int unsigned hnd, bit hv);
        res_item_t r;
        int unsigned b, g, s, t, hs, ng, ns, comb, got;
        r = '0;
        r.status = STAT_OK;
        got = 0;
        case (op)
            OP_ALLOC: r.status = heap_alloc(req, got) ? STAT_OK : STAT_FAIL;
            OP_FREE: if (hv) begin
                if (find_live(hnd, b, g)) give_back(b, g);
                else r.status = STAT_IGNORED;
            end
            OP_REALLOC: begin
                if (!hv) begin
                    r.status = heap_alloc(req, got) ? STAT_OK : STAT_FAIL;
                end else if (!find_live(hnd, b, g)) begin
                    r.status = STAT_IGNORED;
                end else begin
                    s = slot(b, g);
                    t = chunk_need(req);
                    hs = hp_size[s];
                    if (hs >= t) begin
                        got = hnd;
                    end else if (next_is_free(b, g, ng) && hs + hp_size[slot(b, ng)] >= t) begin
                        ns = hp_size[slot(b, ng)];
                        comb = hs + ns;
                        bin_unlink(b, ng);
                        hp_start[slot(b, ng)] = 0;
                        hp_free[slot(b, ng)] = 0;
                        if (comb - t >= SPLIT_MIN) begin
                            make_free_chunk(b, g + t/8, comb - t);
                            hp_size[s] = t;
                            blk_free[b] -= t - hs;
                        end else begin
                            hp_size[s] = comb;
                            blk_free[b] -= ns;
                        end
                        got = hnd;
                    end else if (heap_alloc(req, got)) begin
                        r.copy_needed = 1;
                        r.copy_bytes = ((hs - HDR_BYTES) < req) ? hs - HDR_BYTES : req;
                        r.copy_from = hnd;
                        give_back(b, g);
                    end else begin
                        got = 0;
                        r.status = STAT_FAIL;
                    end
                end
            end
            default: begin
                active_cnt = 1;
                wipe_block(0);
            end
        endcase
        r.result_handle = got;
        // pool upkeep for later stimulus
        if (op == OP_CLEAR) begin
            dead_handles = live_handles;
            live_handles.delete();
        end else if (op == OP_FREE && hv && r.status == STAT_OK) begin
            drop_handle(hnd);
        end else if (r.copy_needed) begin
            drop_handle(hnd);
        end
        if (r.status == STAT_OK && got != 0 && !(op == OP_REALLOC && got == hnd && hv))
            live_handles.push_back(got);
        return r;
    endfunction

    function automatic void drop_handle(int unsigned hnd);
        foreach (live_handles[i])
            if (live_handles[i] == hnd) begin
                live_handles.delete(i);
                break;
            end
        dead_handles.push_back(hnd);
        if (dead_handles.size() > 64) void'(dead_handles.pop_front());
    endfunction

    // Drive one request and predict it when taken
    task automatic send_req(op_t op, int unsigned req, int unsigned hnd, bit hv);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, hnd[17:0], req[23:0]};
        s_tuser <= {hv, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(heap_step(op, req, hnd, hv));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_limit(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[2:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        block_limit = v;
    endtask

    // Receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Result checker
    always @(posedge aclk) begin
        res_item_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item tdata=%h tuser=%h", $realtime,
                         m_tdata, m_tuser);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[17:0] !== exp_r.result_handle) begin
                    $display("%0t: result_handle expected %h got %h", $realtime,
                             exp_r.result_handle, m_tdata[17:0]);
                    errors++;
                end
                if (m_tuser[1:0] !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d", $realtime,
                             exp_r.status, m_tuser[1:0]);
                    errors++;
                end
                if (m_tuser[2] !== exp_r.copy_needed) begin
                    $display("%0t: copy_needed expected %b got %b", $realtime,
                             exp_r.copy_needed, m_tuser[2]);
                    errors++;
                end
                if (m_tdata[41:18] !== exp_r.copy_bytes) begin
                    $display("%0t: copy_bytes expected %h got %h", $realtime,
                             exp_r.copy_bytes, m_tdata[41:18]);
                    errors++;
                end
                if (m_tdata[59:42] !== exp_r.copy_from) begin
                    $display("%0t: copy_from expected %h got %h", $realtime,
                             exp_r.copy_from, m_tdata[59:42]);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned live_pick();
        return live_handles.size() ? live_handles[$urandom_range(live_handles.size()-1)] : 8;
    endfunction

    // Class boundaries, zero and oversize sizes, null and bad handles, clear
    task automatic test_directed();
        int unsigned h;
        send_req(OP_ALLOC, 1, 0, 0);
        send_req(OP_ALLOC, 0, 0, 0);
        send_req(OP_ALLOC, 24'hFFFFFF, 0, 0);
        send_req(OP_ALLOC, 24, 0, 0);
        send_req(OP_ALLOC, 56, 0, 0);
        send_req(OP_ALLOC, 120, 0, 0);
        send_req(OP_ALLOC, 248, 0, 0);
        send_req(OP_ALLOC, 504, 0, 0);
        send_req(OP_ALLOC, 505, 0, 0);
        send_req(OP_ALLOC, BLOCK_BYTES - HDR_BYTES, 0, 0);
        send_req(OP_FREE, 0, 0, 0);
        send_req(OP_FREE, 0, 3, 1);
        send_req(OP_FREE, 0, 13, 1);
        send_req(OP_FREE, 0, 3*BLOCK_BYTES + 8, 1);
        send_req(OP_FREE, 0, 18'h3FFFF, 1);
        h = live_handles[1];
        send_req(OP_FREE, 0, h, 1);
        send_req(OP_FREE, 0, h, 1);
        send_req(OP_REALLOC, 40, 0, 0);
        send_req(OP_REALLOC, 0, live_handles[0], 1);
        send_req(OP_REALLOC, 30, live_handles[0], 1);
        send_req(OP_REALLOC, 3000, live_handles[2], 1);
        send_req(OP_REALLOC, 0, 8, 1);
        send_req(OP_CLEAR, 0, 0, 0);
    endtask

    // Block limit: adds stop at max_blocks, a failed move keeps the old chunk
    task automatic test_block_limit();
        int unsigned h;
        write_limit(1);
        send_req(OP_ALLOC, 40000, 0, 0);
        h = live_pick();
        send_req(OP_ALLOC, 40000, 0, 0);
        send_req(OP_REALLOC, 60000, h, 1);
        send_req(OP_FREE, 0, h, 1);
        write_limit(4);
        send_req(OP_ALLOC, 65000, 0, 0);
        send_req(OP_ALLOC, 65000, 0, 0);
        send_req(OP_ALLOC, 65000, 0, 0);
        send_req(OP_ALLOC, 65000, 0, 0);
        send_req(OP_CLEAR, 0, 0, 0);
        write_limit(2);
    endtask

    function automatic int unsigned rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(600, 1);
        if (r < 90) return $urandom_range(8000, 1);
        if (r < 97) return $urandom_range(70000, 1);
        return $urandom & 24'hFFFFFF;
    endfunction

    function automatic int unsigned rand_handle(output bit hv);
        int r;
        r = $urandom_range(99);
        hv = 1;
        if (r < 85) return live_pick();
        if (r < 91 && dead_handles.size())
            return dead_handles[$urandom_range(dead_handles.size()-1)];
        if (r < 96) return $urandom & 18'h3FFFF;
        hv = 0;
        return $urandom & 18'h3FFFF;
    endfunction

    task automatic test_random(int unsigned n, int s_idle, int m_stall, int unsigned lim);
        int r;
        int unsigned h;
        bit hv;
        write_limit(lim);
        idle_pct = s_idle;
        stall_pct = m_stall;
        repeat (n) begin
            r = $urandom_range(199);
            h = rand_handle(hv);
            if (r < 80) send_req(OP_ALLOC, rand_size(), $urandom & 18'h3FFFF, $urandom);
            else if (r < 140) send_req(OP_FREE, $urandom & 24'hFFFFFF, h, hv);
            else if (r < 198) send_req(OP_REALLOC, rand_size(), h, hv);
            else send_req(OP_CLEAR, $urandom & 24'hFFFFFF, $urandom & 18'h3FFFF, $urandom);
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        heap_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_block_limit();
        test_random(475, 0, 0, 0);
        test_random(475, 83, 0, 3);
        test_random(475, 0, 83, 4);
        test_random(475, 30, 30, 1);
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #200000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/sfla_pkg.sv
design/sfla_ram.sv
design/sfla_ctrl.sv
design/segregated_free_list_allocator.sv
tb/sv/tb_segregated_free_list_allocator.sv
